// ===== design/rdc_pkg.sv =====
// ---------------------------------------------------------------------------
// rdc_pkg: shared types and constants of the random domain classifier
// Character codes, register indexes and reset values, the configuration
// record and the small flag record passed from the statistics to the verdict.
// ---------------------------------------------------------------------------
package rdc_pkg;

   // Field widths fixed by the stream and register formats
   localparam int CHAR_W    = 8;
   localparam int CFG_W     = 8;
   localparam int TENTHS_W  = 4;
   localparam int CSR_IDX_W = 2;
   localparam int RSP_W     = 8;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_MIN_LABEL_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIGIT_RUN_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DIGIT_GROUP_LIMIT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VOWEL_TENTHS      = 2'd3;

   // Register reset values
   localparam logic [CFG_W-1:0]    RST_MIN_LABEL_LENGTH  = 8'd10;
   localparam logic [CFG_W-1:0]    RST_DIGIT_RUN_LIMIT   = 8'd4;
   localparam logic [CFG_W-1:0]    RST_DIGIT_GROUP_LIMIT = 8'd1;
   localparam logic [TENTHS_W-1:0] RST_VOWEL_TENTHS      = 4'd3;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_W     = 8'h77;  // 'w'
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;  // '.'
   localparam logic [CHAR_W-1:0] CH_C     = 8'h63;  // 'c'
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'

   // Prefix tracking: up to three 'w' then a dot, after which it is decided
   localparam logic [2:0] PREFIX_DOT_DUE = 3'd3;
   localparam logic [2:0] PREFIX_DONE    = 3'd4;

   // CDN marker word length and the scale of the vowel share
   localparam logic [3:0] MARK_LEN     = 4'd10;
   localparam logic [3:0] TENTHS_SCALE = 4'd10;
   localparam logic [1:0] DOTS_MAX     = 2'd3;

   // Configuration record
   typedef struct packed {
      logic [CFG_W-1:0]    min_label_length;
      logic [CFG_W-1:0]    digit_run_limit;
      logic [CFG_W-1:0]    digit_group_limit;
      logic [TENTHS_W-1:0] vowel_tenths;
   } cfg_type;

   // Whole-name flags used by the verdict
   typedef struct packed {
      logic       marker_seen;
      logic [1:0] dot_count;
   } name_flags_type;

   // Characters of the CDN marker word, by position
   function automatic logic [CHAR_W-1:0] marker_char(input logic [3:0] idx);
      logic [CHAR_W-1:0] c;
      unique case (idx)
         4'd0:    c = 8'h63;  // c
         4'd1:    c = 8'h6C;  // l
         4'd2:    c = 8'h6F;  // o
         4'd3:    c = 8'h75;  // u
         4'd4:    c = 8'h64;  // d
         4'd5:    c = 8'h66;  // f
         4'd6:    c = 8'h72;  // r
         4'd7:    c = 8'h6F;  // o
         4'd8:    c = 8'h6E;  // n
         4'd9:    c = 8'h74;  // t
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Vowels in either case
   function automatic logic is_vowel(input logic [CHAR_W-1:0] ch);
      logic v;
      v = (ch == 8'h61) || (ch == 8'h65) || (ch == 8'h69) || (ch == 8'h6F) ||
          (ch == 8'h75) || (ch == 8'h41) || (ch == 8'h45) || (ch == 8'h49) ||
          (ch == 8'h4F) || (ch == 8'h55);
      return v;
   endfunction

endpackage

// ===== design/rdc_csr.sv =====
// ---------------------------------------------------------------------------
// rdc_csr: configuration registers
// Holds the four thresholds, written through a plain write port.
// ---------------------------------------------------------------------------
module rdc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rdc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rdc_pkg::CFG_W-1:0]           csr_wdata,
   output rdc_pkg::cfg_type                    cfg
);

   rdc_pkg::cfg_type cfg_ff, cfg_in;

   // Decode the register index of a write.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            rdc_pkg::REG_MIN_LABEL_LENGTH:  cfg_in.min_label_length  = csr_wdata;
            rdc_pkg::REG_DIGIT_RUN_LIMIT:   cfg_in.digit_run_limit   = csr_wdata;
            rdc_pkg::REG_DIGIT_GROUP_LIMIT: cfg_in.digit_group_limit = csr_wdata;
            rdc_pkg::REG_VOWEL_TENTHS:
               cfg_in.vowel_tenths = csr_wdata[rdc_pkg::TENTHS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_label_length  <= rdc_pkg::RST_MIN_LABEL_LENGTH;
         cfg_ff.digit_run_limit   <= rdc_pkg::RST_DIGIT_RUN_LIMIT;
         cfg_ff.digit_group_limit <= rdc_pkg::RST_DIGIT_GROUP_LIMIT;
         cfg_ff.vowel_tenths      <= rdc_pkg::RST_VOWEL_TENTHS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/rdc_stats.sv =====
// ---------------------------------------------------------------------------
// rdc_stats: per-name statistics
// Tracks the "www." prefix, the marker word, dots and the first label's
// length, vowels and digit runs; presents the values after the current
// character and returns to the idle state after the last one.
// ---------------------------------------------------------------------------
module rdc_stats #(
   parameter int COUNT_MAX = 255
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [rdc_pkg::CHAR_W-1:0]      ch,
   input  logic                            last,
   output logic [$clog2(COUNT_MAX+1)-1:0]  label_length,
   output logic [$clog2(COUNT_MAX+1)-1:0]  vowel_count,
   output logic [$clog2(COUNT_MAX+1)-1:0]  longest_run,
   output logic [$clog2(COUNT_MAX+1)-1:0]  run_count,
   output rdc_pkg::name_flags_type         flags
);

   localparam int CNT_W = $clog2(COUNT_MAX+1);
   localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(COUNT_MAX);

   logic [2:0]       prefix_ff, prefix_in;
   logic [3:0]       sub_ff, sub_in;
   logic             seen_ff, seen_in;
   logic [1:0]       dots_ff, dots_in;
   logic             first_ff, first_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] vow_ff, vow_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0] long_ff, long_in;
   logic [CNT_W-1:0] runs_ff, runs_in;
   logic             take;
   logic             digit;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      r = (v >= CNT_TOP) ? CNT_TOP : v + CNT_W'(1);
      return r;
   endfunction

   assign digit = (ch >= rdc_pkg::CH_ZERO) && (ch <= rdc_pkg::CH_NINE);

   // Next statistics after the current character.
   always_comb begin
      sub_in   = sub_ff;
      seen_in  = seen_ff;
      dots_in  = dots_ff;
      first_in = first_ff;
      len_in   = len_ff;
      vow_in   = vow_ff;
      cur_in   = cur_ff;
      long_in  = long_ff;
      runs_in  = runs_ff;
      take     = 1'b1;

      // A completed "www." prefix wipes the name statistics.
      if (prefix_ff < rdc_pkg::PREFIX_DOT_DUE && ch == rdc_pkg::CH_W) begin
         prefix_in = prefix_ff + 3'd1;
      end else if (prefix_ff == rdc_pkg::PREFIX_DOT_DUE && ch == rdc_pkg::CH_DOT) begin
         prefix_in = rdc_pkg::PREFIX_DONE;
         take      = 1'b0;
         sub_in    = '0;
         seen_in   = 1'b0;
         dots_in   = '0;
         first_in  = 1'b1;
         len_in    = '0;
         vow_in    = '0;
         cur_in    = '0;
         long_in   = '0;
         runs_in   = '0;
      end else begin
         prefix_in = rdc_pkg::PREFIX_DONE;
      end

      if (take) begin
         // Marker word search; no proper prefix of it recurs inside it.
         if (sub_ff < rdc_pkg::MARK_LEN && ch == rdc_pkg::marker_char(sub_ff)) begin
            sub_in = sub_ff + 4'd1;
         end else begin
            sub_in = (ch == rdc_pkg::CH_C) ? 4'd1 : 4'd0;
         end
         if (sub_in == rdc_pkg::MARK_LEN) begin
            seen_in = 1'b1;
            sub_in  = '0;
         end

         // Dots end the first label; other characters feed its statistics.
         if (ch == rdc_pkg::CH_DOT) begin
            if (dots_ff < rdc_pkg::DOTS_MAX) begin
               dots_in = dots_ff + 2'd1;
            end
            first_in = 1'b0;
         end else if (first_ff) begin
            len_in = sat_inc(len_ff);
            if (digit) begin
               if (cur_ff == '0) begin
                  runs_in = sat_inc(runs_ff);
               end
               cur_in = sat_inc(cur_ff);
               if (cur_in > long_ff) begin
                  long_in = cur_in;
               end
            end else begin
               cur_in = '0;
               if (rdc_pkg::is_vowel(ch)) begin
                  vow_in = sat_inc(vow_ff);
               end
            end
         end
      end
   end

   // State registers; the last character of a name returns them to idle.
   always_ff @(posedge clock) begin
      if (reset || (advance && last)) begin
         prefix_ff <= '0;
         sub_ff    <= '0;
         seen_ff   <= 1'b0;
         dots_ff   <= '0;
         first_ff  <= 1'b1;
         len_ff    <= '0;
         vow_ff    <= '0;
         cur_ff    <= '0;
         long_ff   <= '0;
         runs_ff   <= '0;
      end else if (advance) begin
         prefix_ff <= prefix_in;
         sub_ff    <= sub_in;
         seen_ff   <= seen_in;
         dots_ff   <= dots_in;
         first_ff  <= first_in;
         len_ff    <= len_in;
         vow_ff    <= vow_in;
         cur_ff    <= cur_in;
         long_ff   <= long_in;
         runs_ff   <= runs_in;
      end
   end

   assign label_length      = len_in;
   assign vowel_count       = vow_in;
   assign longest_run       = long_in;
   assign run_count         = runs_in;
   assign flags.marker_seen = seen_in;
   assign flags.dot_count   = dots_in;

endmodule

// ===== design/rdc_judge.sv =====
// ---------------------------------------------------------------------------
// rdc_judge: verdict logic
// Applies the dot, length, digit-run and vowel-share rules to the
// statistics of a complete name.
// ---------------------------------------------------------------------------
module rdc_judge #(
   parameter int COUNT_MAX = 255
) (
   input  rdc_pkg::cfg_type                cfg,
   input  rdc_pkg::name_flags_type         flags,
   input  logic [$clog2(COUNT_MAX+1)-1:0]  label_length,
   input  logic [$clog2(COUNT_MAX+1)-1:0]  vowel_count,
   input  logic [$clog2(COUNT_MAX+1)-1:0]  longest_run,
   input  logic [$clog2(COUNT_MAX+1)-1:0]  run_count,
   output logic                            is_random
);

   localparam int CNT_W = $clog2(COUNT_MAX+1);
   localparam int CMP_W = (CNT_W > rdc_pkg::CFG_W) ? CNT_W : rdc_pkg::CFG_W;
   localparam int PRD_W = CNT_W + rdc_pkg::TENTHS_W;

   logic             excluded;
   logic             too_short;
   logic             long_digits;
   logic             many_groups;
   logic [PRD_W-1:0] vowel_scaled;
   logic [PRD_W-1:0] length_scaled;
   logic             few_vowels;

   // Names that are never judged: several dots without the CDN word, no dot.
   assign excluded = (!flags.marker_seen && flags.dot_count > 2'd1) ||
                     (flags.dot_count == 2'd0);

   assign too_short   = CMP_W'(label_length) < CMP_W'(cfg.min_label_length);
   assign long_digits = CMP_W'(longest_run)  > CMP_W'(cfg.digit_run_limit);
   assign many_groups = CMP_W'(run_count)    > CMP_W'(cfg.digit_group_limit);

   // Vowel share as an exact integer comparison against tenths of the length.
   assign vowel_scaled  = PRD_W'(vowel_count) * PRD_W'(rdc_pkg::TENTHS_SCALE);
   assign length_scaled = PRD_W'(cfg.vowel_tenths) * PRD_W'(label_length);
   assign few_vowels    = vowel_scaled < length_scaled;

   assign is_random = !excluded && !too_short &&
                      (long_digits || many_groups || few_vowels);

endmodule

// ===== design/random_domain_classifier.sv =====
// ---------------------------------------------------------------------------
// random_domain_classifier: flags machine-generated domain names
// Order: the last character's transaction loads the input register; once the
// result register is free, the verdict is written into it and offered.
// Throughput: one character per cycle; a stalled result blocks the input only
// once the next last character sits in the input register.
// Reset: synchronous; clears the pipeline and name state, loads the default
// thresholds.
// ---------------------------------------------------------------------------
module random_domain_classifier #(
   parameter int COUNT_MAX = 255
) (
   input  logic                              clock,
   input  logic                              reset,
   // Character stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rdc_pkg::CHAR_W-1:0]        req_tdata,   // [7:0] character
   input  logic                              req_tlast,
   // Verdict stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rdc_pkg::RSP_W-1:0]         rsp_tdata,   // [0] is_random, [7:1] zero
   // Configuration writes
   input  logic                              csr_we,
   input  logic [rdc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rdc_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int CNT_W = $clog2(COUNT_MAX+1);

   logic                        in_valid_ff, in_valid_in;
   logic [rdc_pkg::CHAR_W-1:0]  in_char_ff;
   logic                        in_last_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_random_ff;
   logic                        rsp_free;
   logic                        advance;
   logic                        verdict;
   rdc_pkg::cfg_type            cfg;
   rdc_pkg::name_flags_type     flags;
   logic [CNT_W-1:0]            label_length;
   logic [CNT_W-1:0]            vowel_count;
   logic [CNT_W-1:0]            longest_run;
   logic [CNT_W-1:0]            run_count;

   // Flow control: a character without a verdict never waits on the output.
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign advance     = in_valid_ff && (!in_last_ff || rsp_free);
   assign req_tready  = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) ? 1'b1 :
                         (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (advance && in_last_ff) ? 1'b1 :
                         (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   rdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rdc_stats #(.COUNT_MAX(COUNT_MAX)) u_stats (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .ch           (in_char_ff),
      .last         (in_last_ff),
      .label_length (label_length),
      .vowel_count  (vowel_count),
      .longest_run  (longest_run),
      .run_count    (run_count),
      .flags        (flags)
   );

   rdc_judge #(.COUNT_MAX(COUNT_MAX)) u_judge (
      .cfg          (cfg),
      .flags        (flags),
      .label_length (label_length),
      .vowel_count  (vowel_count),
      .longest_run  (longest_run),
      .run_count    (run_count),
      .is_random    (verdict)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && in_last_ff) begin
         rsp_random_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(rdc_pkg::RSP_W-1){1'b0}}, rsp_random_ff};

endmodule
